>>> design/cap_pkg.sv
// ============================================================================
// cap_pkg
// Types, register codes, reset values and saturation helpers shared by the
// cascaded angle/rate controller modules.
// ============================================================================
`default_nettype none

package cap_pkg;

    localparam int ADDR_W = 5;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 66;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_RATE_KP      = 3'd0;
    localparam logic [2:0] REG_RATE_KI      = 3'd1;
    localparam logic [2:0] REG_RATE_KD      = 3'd2;
    localparam logic [2:0] REG_ANGLE_KP     = 3'd3;
    localparam logic [2:0] REG_POS_LIMIT    = 3'd4;
    localparam logic [2:0] REG_NEG_LIMIT    = 3'd5;
    localparam logic [2:0] REG_STICK_CENTER = 3'd6;
    localparam logic [2:0] REG_OUTPUT_LIMIT = 3'd7;

    localparam logic [23:0] POS_LIMIT_RST    = 24'd7680;
    localparam logic [23:0] NEG_LIMIT_RST    = 24'hFFE200;
    localparam logic [11:0] STICK_CENTER_RST = 12'd1500;
    localparam logic [22:0] OUTPUT_LIMIT_RST = 23'd102400;

    // Division of the stick product by 500: the magnitude is clamped so the
    // quotient cannot pass 2^23, shifted right by two, then multiplied by
    // ceil(2^37 / 125) and shifted right by 37. Exact for 30-bit dividends.
    localparam logic [35:0] DIV_CLAMP = 36'd4194304000;
    localparam logic [30:0] DIV_RECIP = 31'd1099511628;
    localparam int          DIV_SHIFT = 37;

    typedef struct packed {
        logic [15:0] rate_kp;
        logic [15:0] rate_ki;
        logic [15:0] rate_kd;
        logic [15:0] angle_kp;
        logic [23:0] pos_angle_limit;
        logic [23:0] neg_angle_limit;
        logic [11:0] stick_center;
        logic [22:0] output_limit;
    } cap_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TGT,
        ST_DIV,
        ST_AERR,
        ST_TRATE,
        ST_ERR,
        ST_PROP,
        ST_INT,
        ST_DER,
        ST_SUM,
        ST_FIN
    } cap_state_t;

    function automatic logic signed [23:0] sat_s24(input logic signed [47:0] v);
        logic signed [23:0] r;
        if (v > 48'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -48'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_s32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -48'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/cap_mul.sv
// ============================================================================
// cap_mul
// Shared signed multiplier with a registered product, used for one product in
// each multiplying step of the controller sequence.
// ============================================================================
`default_nettype none

module cap_mul (
    input  wire logic                                  aclk,
    input  wire logic signed [cap_pkg::MUL_W-1:0]      mul_a,
    input  wire logic signed [cap_pkg::MUL_W-1:0]      mul_b,
    output logic signed [cap_pkg::PROD_W-1:0]          prod
);

    logic signed [cap_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

>>> design/cap_cfg.sv
// ============================================================================
// cap_cfg
// APB-style register file holding the controller gains, limits and stick
// center.
// ============================================================================
`default_nettype none

module cap_cfg (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cap_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output cap_pkg::cap_cfg_t                cfg
);

    cap_pkg::cap_cfg_t cfg_reg;
    logic              wr_en;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rate_kp         <= 16'd0;
            cfg_reg.rate_ki         <= 16'd0;
            cfg_reg.rate_kd         <= 16'd0;
            cfg_reg.angle_kp        <= 16'd0;
            cfg_reg.pos_angle_limit <= cap_pkg::POS_LIMIT_RST;
            cfg_reg.neg_angle_limit <= cap_pkg::NEG_LIMIT_RST;
            cfg_reg.stick_center    <= cap_pkg::STICK_CENTER_RST;
            cfg_reg.output_limit    <= cap_pkg::OUTPUT_LIMIT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                cap_pkg::REG_RATE_KP:      cfg_reg.rate_kp         <= pwdata[15:0];
                cap_pkg::REG_RATE_KI:      cfg_reg.rate_ki         <= pwdata[15:0];
                cap_pkg::REG_RATE_KD:      cfg_reg.rate_kd         <= pwdata[15:0];
                cap_pkg::REG_ANGLE_KP:     cfg_reg.angle_kp        <= pwdata[15:0];
                cap_pkg::REG_POS_LIMIT:    cfg_reg.pos_angle_limit <= pwdata[23:0];
                cap_pkg::REG_NEG_LIMIT:    cfg_reg.neg_angle_limit <= pwdata[23:0];
                cap_pkg::REG_STICK_CENTER: cfg_reg.stick_center    <= pwdata[11:0];
                cap_pkg::REG_OUTPUT_LIMIT: cfg_reg.output_limit    <= pwdata[22:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            cap_pkg::REG_RATE_KP:      prdata = {16'd0, cfg_reg.rate_kp};
            cap_pkg::REG_RATE_KI:      prdata = {16'd0, cfg_reg.rate_ki};
            cap_pkg::REG_RATE_KD:      prdata = {16'd0, cfg_reg.rate_kd};
            cap_pkg::REG_ANGLE_KP:     prdata = {16'd0, cfg_reg.angle_kp};
            cap_pkg::REG_POS_LIMIT:    prdata = {8'd0, cfg_reg.pos_angle_limit};
            cap_pkg::REG_NEG_LIMIT:    prdata = {8'd0, cfg_reg.neg_angle_limit};
            cap_pkg::REG_STICK_CENTER: prdata = {20'd0, cfg_reg.stick_center};
            cap_pkg::REG_OUTPUT_LIMIT: prdata = {9'd0, cfg_reg.output_limit};
            default:                   prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> design/cascaded_angle_rate_pid.sv
// One shared 33x33 multiplier is stepped through six products (stick scale,
// divide by 500, outer gain, P, I, D). A new item is taken only while idle, once
// the last one is done; a held result stalls the final step until the output
// register frees up.
// Reset: synchronous, active-low aresetn restores register defaults and clears
// the error history, accumulator and output valid.
// ============================================================================
// cascaded_angle_rate_pid
// One axis of a cascaded attitude controller: stick to target angle, P outer
// loop to target rate, incremental PID inner loop with runaway reset.
// ============================================================================
`default_nettype none

module cascaded_angle_rate_pid (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // [11:0] stick_value, [35:12] measured_angle, [59:36] measured_rate
    input  wire logic [63:0]                 s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [23:0] drive, [24] history_cleared
    output logic [31:0]                      m_tdata,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cap_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    cap_pkg::cap_cfg_t  cfg;
    cap_pkg::cap_state_t state_reg, state_next;

    logic signed [cap_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [cap_pkg::PROD_W-1:0] prod;

    // Item and intermediate registers.
    logic signed [12:0] off_reg;
    logic signed [23:0] ang_reg;
    logic signed [23:0] rate_reg;
    logic               lsign_reg;
    logic signed [23:0] aerr_reg;
    logic signed [23:0] e0_reg;
    logic signed [43:0] sum_reg;
    logic               cleared_reg;

    // Controller history.
    logic signed [23:0] last_error_reg;
    logic signed [23:0] older_error_reg;
    logic signed [31:0] accum_reg;

    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;

    logic               in_acc;
    logic               out_free;

    // Combinational datapath terms.
    logic [11:0]        stick_mag;
    logic signed [23:0] lim_sel;
    logic [23:0]        lim_mag;
    logic [35:0]        div_mag;
    logic [35:0]        div_clamped;
    logic [23:0]        quot;
    logic signed [23:0] target;
    logic signed [23:0] trate;
    logic signed [24:0] d1;
    logic signed [26:0] d2;
    logic signed [35:0] sum_q;
    logic signed [31:0] acc_new;
    logic signed [32:0] lim_s;
    logic signed [23:0] drive;
    logic               runaway;

    cap_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cap_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    assign s_tready = (state_reg == cap_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        // A negative offset uses the negative limit times the negated offset,
        // so the second factor is always the offset magnitude.
        stick_mag = off_reg[12] ? 12'(-off_reg) : off_reg[11:0];
        lim_sel   = off_reg[12] ? signed'(cfg.neg_angle_limit)
                                : signed'(cfg.pos_angle_limit);
        lim_mag   = lim_sel[23] ? 24'(-lim_sel) : lim_sel;

        div_mag     = prod[35:0];
        div_clamped = (div_mag > cap_pkg::DIV_CLAMP) ? cap_pkg::DIV_CLAMP : div_mag;

        quot = prod[cap_pkg::DIV_SHIFT+23:cap_pkg::DIV_SHIFT];
        if (lsign_reg) begin
            target = -signed'(quot);
        end else if (quot[23]) begin
            target = 24'sh7FFFFF;
        end else begin
            target = signed'(quot);
        end

        trate = cap_pkg::sat_s24(signed'(prod[55:8]));

        d1 = 25'(e0_reg) - 25'(last_error_reg);
        d2 = 27'(e0_reg) - (27'(last_error_reg) <<< 1) + 27'(older_error_reg);

        sum_q   = sum_reg[43:8];
        acc_new = cap_pkg::sat_s32(48'(accum_reg) + 48'(sum_q));
        lim_s   = signed'({10'd0, cfg.output_limit});
        if (33'(acc_new) > lim_s) begin
            drive = signed'({1'b0, cfg.output_limit});
        end else if (33'(acc_new) < -lim_s) begin
            drive = -signed'({1'b0, cfg.output_limit});
        end else begin
            drive = acc_new[23:0];
        end

        runaway = (33'(accum_reg) > lim_s) || (33'(accum_reg) < -lim_s);
    end

    // Multiplier operand selection.
    always_comb begin
        case (state_reg)
            cap_pkg::ST_TGT: begin
                mul_a = signed'({9'd0, lim_mag});
                mul_b = signed'({21'd0, stick_mag});
            end
            cap_pkg::ST_DIV: begin
                mul_a = signed'({3'd0, div_clamped[31:2]});
                mul_b = signed'({2'd0, cap_pkg::DIV_RECIP});
            end
            cap_pkg::ST_TRATE: begin
                mul_a = signed'({17'd0, cfg.angle_kp});
                mul_b = 33'(aerr_reg);
            end
            cap_pkg::ST_PROP: begin
                mul_a = signed'({17'd0, cfg.rate_kp});
                mul_b = 33'(d1);
            end
            cap_pkg::ST_INT: begin
                mul_a = signed'({17'd0, cfg.rate_ki});
                mul_b = 33'(e0_reg);
            end
            cap_pkg::ST_DER: begin
                mul_a = signed'({17'd0, cfg.rate_kd});
                mul_b = 33'(d2);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        case (state_reg)
            cap_pkg::ST_IDLE:  state_next = in_acc ? cap_pkg::ST_TGT : cap_pkg::ST_IDLE;
            cap_pkg::ST_TGT:   state_next = cap_pkg::ST_DIV;
            cap_pkg::ST_DIV:   state_next = cap_pkg::ST_AERR;
            cap_pkg::ST_AERR:  state_next = cap_pkg::ST_TRATE;
            cap_pkg::ST_TRATE: state_next = cap_pkg::ST_ERR;
            cap_pkg::ST_ERR:   state_next = cap_pkg::ST_PROP;
            cap_pkg::ST_PROP:  state_next = cap_pkg::ST_INT;
            cap_pkg::ST_INT:   state_next = cap_pkg::ST_DER;
            cap_pkg::ST_DER:   state_next = cap_pkg::ST_SUM;
            cap_pkg::ST_SUM:   state_next = cap_pkg::ST_FIN;
            cap_pkg::ST_FIN:   state_next = out_free ? cap_pkg::ST_IDLE : cap_pkg::ST_FIN;
            default:           state_next = cap_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cap_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Payload registers of the sequence.
    always_ff @(posedge aclk) begin
        case (state_reg)
            cap_pkg::ST_IDLE: begin
                if (in_acc) begin
                    off_reg  <= signed'({1'b0, s_tdata[11:0]})
                              - signed'({1'b0, cfg.stick_center});
                    ang_reg  <= s_tdata[35:12];
                    rate_reg <= s_tdata[59:36];
                end
            end
            cap_pkg::ST_TGT: begin
                lsign_reg <= lim_sel[23];
            end
            cap_pkg::ST_AERR: begin
                aerr_reg <= cap_pkg::sat_s24(48'(target) - 48'(ang_reg));
            end
            cap_pkg::ST_ERR: begin
                e0_reg      <= cap_pkg::sat_s24(48'(trate) - 48'(rate_reg));
                cleared_reg <= runaway;
            end
            cap_pkg::ST_INT: begin
                sum_reg <= prod[43:0];
            end
            cap_pkg::ST_DER, cap_pkg::ST_SUM: begin
                sum_reg <= sum_reg + prod[43:0];
            end
            default: begin
            end
        endcase
    end

    // Controller history and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_error_reg  <= '0;
            older_error_reg <= '0;
            accum_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (state_reg == cap_pkg::ST_ERR && runaway) begin
                // Runaway reset: the history is cleared before this item's PID step.
                last_error_reg  <= '0;
                older_error_reg <= '0;
                accum_reg       <= '0;
            end
            if (state_reg == cap_pkg::ST_FIN && out_free) begin
                older_error_reg <= last_error_reg;
                last_error_reg  <= e0_reg;
                accum_reg       <= acc_new;
                m_tvalid_reg    <= 1'b1;
                m_tdata_reg     <= {7'd0, cleared_reg, drive};
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> tb/cascaded_angle_rate_pid_tb.sv
// ============================================================================
// cascaded_angle_rate_pid_tb
// Self-checking testbench for one controller axis. A short table of directed
// items and register writes runs first, then several random phases, each under
// its own register setting. Every accepted item is run through a local model
// of the cascaded angle/rate loop; each result is compared against it, or against a directed item's expected value.
// ============================================================================

module cascaded_angle_rate_pid_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cap_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 11;
    localparam int PHASE_COUNT     = 6;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int HOLD_OFF_CYCLES = 240;
    localparam int DRAIN_CYCLES    = 20;
    localparam int REPORT_LIMIT    = 100;
    localparam int REG_BITS [8]    = '{16, 16, 16, 16, 24, 24, 12, 23};

    typedef struct packed {
        logic [23:0] drive;
        logic        cleared;
    } drive_result_t;

    typedef struct packed {
        logic          is_cfg;
        logic [2:0]    reg_idx;
        logic [31:0]   value;
        logic [11:0]   stick;
        logic [23:0]   angle;
        logic [23:0]   rate;
        logic          has_exp;
        drive_result_t exp;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Model of the controller: register copy and loop history.
    cap_cfg_t cfg_model;
    longint   err_last;
    longint   err_older;
    longint   acc_model;

    drive_result_t drive_q[$];
    stim_row_t     directed_rows[$];
    int            error_count   = 0;
    int            hold_request  = 0;
    bit            rx_free       = 1'b1;
    bit            tx_free       = 1'b1;

    always #(HALF_PERIOD) aclk = ~aclk;

    cascaded_angle_rate_pid u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    function automatic longint clip_signed(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // One control step: target angle, outer P, incremental inner PID, clamp.
    function automatic drive_result_t axis_update(input logic [11:0] stick,
                                                  input logic [23:0] angle,
                                                  input logic [23:0] rate);
        longint off, target, aerr, trate, e0, sum, acc, lim, drv;
        drive_result_t res;
        lim = longint'(cfg_model.output_limit);
        off = longint'(stick) - longint'(cfg_model.stick_center);
        if (off >= 0) begin
            target = longint'($signed(cfg_model.pos_angle_limit)) * off / 500;
        end else begin
            target = longint'($signed(cfg_model.neg_angle_limit)) * (-off) / 500;
        end
        target = clip_signed(target, 24);
        aerr   = clip_signed(target - longint'($signed(angle)), 24);
        trate  = clip_signed((longint'(cfg_model.angle_kp) * aerr) >>> 8, 24);
        e0     = clip_signed(trate - longint'($signed(rate)), 24);
        res.cleared = 1'b0;
        // A runaway accumulator from the last step wipes the history first.
        if (acc_model > lim || acc_model < -lim) begin
            err_last    = 0;
            err_older   = 0;
            acc_model   = 0;
            res.cleared = 1'b1;
        end
        sum = longint'(cfg_model.rate_kp) * (e0 - err_last)
            + longint'(cfg_model.rate_ki) * e0
            + longint'(cfg_model.rate_kd) * (e0 - 2 * err_last + err_older);
        acc       = clip_signed(acc_model + (sum >>> 8), 32);
        err_older = err_last;
        err_last  = e0;
        acc_model = acc;
        drv = (acc > lim) ? lim : ((acc < -lim) ? -lim : acc);
        res.drive = drv[23:0];
        return res;
    endfunction

    function automatic void load_register(input logic [2:0] idx, input logic [31:0] value);
        case (idx)
            REG_RATE_KP:      cfg_model.rate_kp         = value[15:0];
            REG_RATE_KI:      cfg_model.rate_ki         = value[15:0];
            REG_RATE_KD:      cfg_model.rate_kd         = value[15:0];
            REG_ANGLE_KP:     cfg_model.angle_kp        = value[15:0];
            REG_POS_LIMIT:    cfg_model.pos_angle_limit = value[23:0];
            REG_NEG_LIMIT:    cfg_model.neg_angle_limit = value[23:0];
            REG_STICK_CENTER: cfg_model.stick_center    = value[11:0];
            REG_OUTPUT_LIMIT: cfg_model.output_limit    = value[22:0];
            default: begin
            end
        endcase
    endfunction

    function automatic void add_cfg(input logic [2:0] idx, input logic [31:0] value);
        stim_row_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.value   = value;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_item(input logic [11:0] stick, input logic [23:0] angle,
                                     input logic [23:0] rate);
        stim_row_t r;
        r = '0;
        r.stick = stick;
        r.angle = angle;
        r.rate  = rate;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_item_expect(input logic [11:0] stick, input logic [23:0] angle,
                                            input logic [23:0] rate, input logic [23:0] drive,
                                            input logic cleared);
        stim_row_t r;
        r = '0;
        r.stick       = stick;
        r.angle       = angle;
        r.rate        = rate;
        r.has_exp     = 1'b1;
        r.exp.drive   = drive;
        r.exp.cleared = cleared;
        directed_rows.push_back(r);
    endfunction

    function automatic logic [23:0] pick_q16();
        logic [23:0] v;
        case ($urandom_range(0, 9))
            0:       v = 24'h7FFFFF;
            1:       v = 24'h800000;
            2:       v = $urandom_range(0, 1) ? 24'h000000 : 24'hFFFFFF;
            3, 4:    v = 24'($urandom);
            default: v = 24'(int'($urandom_range(0, 40000)) - 20000);
        endcase
        return v;
    endfunction

    function automatic logic [11:0] pick_stick();
        logic [11:0] v;
        int c;
        case ($urandom_range(0, 7))
            0:    v = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            1, 2: v = 12'($urandom);
            default: begin
                c = int'(cfg_model.stick_center) + int'($urandom_range(0, 1200)) - 600;
                v = (c < 0) ? 12'd0 : ((c > 4095) ? 12'hFFF : 12'(c));
            end
        endcase
        return v;
    endfunction

    // Setup and access phase, then the bus returns to idle.
    task automatic apb_cycle(input logic write, input logic [2:0] idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        logic [31:0] mask;
        apb_cycle(1'b1, idx, value, rd);
        load_register(idx, value);
        apb_cycle(1'b0, idx, 32'd0, rd);
        mask = (32'd1 << REG_BITS[idx]) - 32'd1;
        if ((rd & mask) != (value & mask)) begin
            report_mismatch($sformatf("register %0d reads %h after writing %h", idx, rd, value));
        end
    endtask

    task automatic offer_item(input logic [11:0] stick, input logic [23:0] angle,
                              input logic [23:0] rate, input logic typed,
                              input drive_result_t typed_res);
        drive_result_t res;
        s_tdata  <= {4'b0000, rate, angle, stick};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        res = axis_update(stick, angle, rate);
        drive_q.push_back(typed ? typed_res : res);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (drive_q.size() != 0) @(posedge aclk);
    endtask

    task automatic program_phase(input int phase);
        int i;
        case (phase)
            0: begin
                write_register(REG_RATE_KP, 32'd300);
                write_register(REG_RATE_KI, 32'd40);
                write_register(REG_RATE_KD, 32'd150);
                write_register(REG_ANGLE_KP, 32'd512);
                write_register(REG_POS_LIMIT, 32'd7680);
                write_register(REG_NEG_LIMIT, 32'hFFFFE200);
                write_register(REG_STICK_CENTER, 32'd1500);
                write_register(REG_OUTPUT_LIMIT, 32'd102400);
            end
            1: begin
                // Small output limit with lively gains: the runaway reset fires often.
                write_register(REG_RATE_KP, $urandom_range(0, 4000));
                write_register(REG_RATE_KI, $urandom_range(0, 2000));
                write_register(REG_RATE_KD, $urandom_range(0, 4000));
                write_register(REG_ANGLE_KP, $urandom_range(0, 3000));
                write_register(REG_OUTPUT_LIMIT, $urandom_range(0, 20000));
            end
            2: begin
                write_register(REG_POS_LIMIT, 32'd0);
                write_register(REG_NEG_LIMIT, 32'd0);
                write_register(REG_RATE_KP, 32'd200);
                write_register(REG_RATE_KI, 32'd20);
                write_register(REG_RATE_KD, 32'd50);
                write_register(REG_ANGLE_KP, $urandom_range(0, 65535));
                write_register(REG_OUTPUT_LIMIT, 32'd102400);
            end
            3: begin
                write_register(REG_RATE_KP, 32'hFFFF);
                write_register(REG_RATE_KI, 32'hFFFF);
                write_register(REG_RATE_KD, 32'hFFFF);
                write_register(REG_ANGLE_KP, 32'hFFFF);
                write_register(REG_POS_LIMIT, 32'h7FFFFF);
                write_register(REG_NEG_LIMIT, 32'h800000);
                write_register(REG_STICK_CENTER, $urandom_range(0, 1) ? 32'd4095 : 32'd0);
                write_register(REG_OUTPUT_LIMIT, 32'h7FFFFF);
            end
            4: begin
                write_register(REG_RATE_KP, 32'd0);
                write_register(REG_RATE_KD, 32'd0);
                write_register(REG_RATE_KI, 32'hFFFF);
                write_register(REG_ANGLE_KP, 32'd256);
                write_register(REG_POS_LIMIT, 32'h800000);
                write_register(REG_NEG_LIMIT, 32'h7FFFFF);
                write_register(REG_STICK_CENTER, 32'd2048);
                write_register(REG_OUTPUT_LIMIT, 32'd0);
            end
            default: begin
                // Full 32-bit values, so the upper bits must be dropped.
                for (i = 0; i < 8; i++) begin
                    write_register(3'(i), $urandom);
                end
            end
        endcase
    endtask

    // Result side: compare each accepted result, then pick the next ready.
    initial begin : result_sink
        logic [15:0]   pattern;
        int            hold;
        int            steps;
        drive_result_t want;
        pattern = '1;
        hold    = 0;
        steps   = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (drive_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                end else begin
                    want = drive_q.pop_front();
                    if (m_tdata[23:0] !== want.drive) begin
                        report_mismatch($sformatf("drive %0d, expected %0d",
                            $signed(m_tdata[23:0]), $signed(want.drive)));
                    end
                    if (m_tdata[24] !== want.cleared) begin
                        report_mismatch($sformatf("history_cleared %b, expected %b",
                            m_tdata[24], want.cleared));
                    end
                end
            end
            if (hold_request != 0) begin
                hold         = hold_request;
                hold_request = 0;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (rx_free) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= pattern[0];
                pattern = {pattern[0], pattern[15:1]};
                steps++;
                if (steps == 16) begin
                    steps   = 0;
                    pattern = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom) | 16'($urandom);
                end
            end
        end
    end

    initial begin : stimulus
        stim_row_t row;
        int        phase;
        int        n;
        int        burst_left;

        cfg_model.rate_kp         = '0;
        cfg_model.rate_ki         = '0;
        cfg_model.rate_kd         = '0;
        cfg_model.angle_kp        = '0;
        cfg_model.pos_angle_limit = POS_LIMIT_RST;
        cfg_model.neg_angle_limit = NEG_LIMIT_RST;
        cfg_model.stick_center    = STICK_CENTER_RST;
        cfg_model.output_limit    = OUTPUT_LIMIT_RST;
        err_last  = 0;
        err_older = 0;
        acc_model = 0;

        // With every gain at zero after reset the output stays at zero.
        add_item_expect(12'h000, 24'h7FFFFF, 24'h800000, 24'd0, 1'b0);
        add_item_expect(12'hFFF, 24'h800000, 24'h7FFFFF, 24'd0, 1'b0);
        add_item_expect(12'd1500, 24'd0, 24'd0, 24'd0, 1'b0);
        add_item_expect(12'd2000, 24'hFFFFFF, 24'h555555, 24'd0, 1'b0);
        add_cfg(REG_RATE_KP, 32'd256);
        add_cfg(REG_RATE_KI, 32'd128);
        add_cfg(REG_RATE_KD, 32'd512);
        add_cfg(REG_ANGLE_KP, 32'd1024);
        add_cfg(REG_OUTPUT_LIMIT, 32'd5000);
        add_item(12'd2000, 24'd0, 24'd0);
        add_item(12'd1000, 24'd100, 24'hFFFFCE);
        add_item(12'd1500, 24'h7FFFFF, 24'h800000);
        add_item(12'd1500, 24'd0, 24'd0);
        add_item(12'hFFF, 24'h800000, 24'h7FFFFF);
        add_item(12'h000, 24'd0, 24'd0);
        // Yaw: both angle limits at zero.
        add_cfg(REG_POS_LIMIT, 32'd0);
        add_cfg(REG_NEG_LIMIT, 32'd0);
        add_item(12'h000, 24'h001000, 24'd0);
        add_item(12'hFFF, 24'hFFF000, 24'h000100);
        add_cfg(REG_RATE_KP, 32'hFFFF);
        add_cfg(REG_RATE_KI, 32'hFFFF);
        add_cfg(REG_RATE_KD, 32'hFFFF);
        add_cfg(REG_ANGLE_KP, 32'hFFFF);
        add_cfg(REG_POS_LIMIT, 32'h7FFFFF);
        add_cfg(REG_NEG_LIMIT, 32'h800000);
        add_cfg(REG_STICK_CENTER, 32'd0);
        add_cfg(REG_OUTPUT_LIMIT, 32'h7FFFFF);
        add_item(12'hFFF, 24'h800000, 24'h7FFFFF);
        add_item(12'hFFF, 24'h800000, 24'h7FFFFF);
        add_item(12'h000, 24'h7FFFFF, 24'h800000);
        add_cfg(REG_STICK_CENTER, 32'd4095);
        add_cfg(REG_OUTPUT_LIMIT, 32'd0);
        add_item(12'h000, 24'd0, 24'd0);
        add_item(12'hFFF, 24'h123456, 24'hABCDEF);
        add_item(12'h000, 24'h800000, 24'h7FFFFF);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                drain_results();
                write_register(row.reg_idx, row.value);
            end else begin
                offer_item(row.stick, row.angle, row.rate, row.has_exp, row.exp);
            end
        end

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            drain_results();
            program_phase(phase);
            rx_free    = (phase == 0);
            tx_free    = (phase == 0) || (phase == 2);
            burst_left = 0;
            // Hold the result side off while items keep coming, so the block fills up.
            if (phase == 2) begin
                hold_request = HOLD_OFF_CYCLES;
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                offer_item(pick_stick(), pick_q16(), pick_q16(), 1'b0, '0);
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    if (!tx_free) begin
                        idle_gap($urandom_range(1, 6));
                    end
                end else begin
                    burst_left--;
                end
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("cascaded_angle_rate_pid verification clean");
        end else begin
            $display("cascaded_angle_rate_pid verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("cascaded_angle_rate_pid verification failed");
        $finish;
    end

endmodule

>>> filelist.f
design/cap_pkg.sv
design/cap_mul.sv
design/cap_cfg.sv
design/cascaded_angle_rate_pid.sv
tb/cascaded_angle_rate_pid_tb.sv
